/* rtl/core/assert_macros.svh */
// Assertion helpers for the core RTL; bmpck_back is the file that includes them.
// Both macros clock on the rising edge and stay quiet while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/bmpck_pkg.sv */
package bmpck_pkg;

    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_PIXEL     = 1'b1;

    localparam logic [1:0] MODE_PAL8   = 2'd0;
    localparam logic [1:0] MODE_BGR24  = 2'd1;
    localparam logic [1:0] MODE_BGRA32 = 2'd2;

    localparam logic [2:0] REG_PIXEL_MODE    = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_ROWS_REVERSED = 3'd3;
    localparam logic [2:0] REG_KEY_GREEN     = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } in_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
    } out_t;

    typedef struct packed {
        logic [1:0]  pixel_mode;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        rows_reversed;
        logic [7:0]  key_green;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_PAL_WR = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_DIRECT = 2'd2
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
    } entry_t;

endpackage

/* rtl/core/bmpck_front.sv */
module bmpck_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmpck_pkg::cfg_t     cfg,
    input  logic                cfg_restart,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmpck_pkg::in_t      s_data,
    input  logic                q_ready,
    output logic                q_push,
    output bmpck_pkg::entry_t   q_entry
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [1:0]       phase_reg,   phase_next;
    logic [23:0]      held_reg,    held_next;
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [1:0]       pad_reg,     pad_next;

    logic [DIM_W-1:0] width_c, height_c;
    logic [DIM_W-1:0] col_sum, row_sum, row_dest;
    logic [31:0]      col_wide, row_wide;
    logic [2:0]       bpp;
    logic [1:0]       pad_prod;
    logic             accept;

    // Clamp the frame size into 1..MAX_DIM.
    always_comb begin
        if (cfg.image_width == '0) begin
            width_c = DIM_W'(1);
        end else if (32'(cfg.image_width) > MAX_DIM) begin
            width_c = DIM_W'(MAX_DIM);
        end else begin
            width_c = DIM_W'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            height_c = DIM_W'(1);
        end else if (32'(cfg.image_height) > MAX_DIM) begin
            height_c = DIM_W'(MAX_DIM);
        end else begin
            height_c = DIM_W'(cfg.image_height);
        end
    end

    always_comb begin
        unique case (cfg.pixel_mode)
            bmpck_pkg::MODE_PAL8:  bpp = 3'd1;
            bmpck_pkg::MODE_BGR24: bpp = 3'd3;
            default:               bpp = 3'd4;
        endcase
    end

    assign col_sum  = DIM_W'(col_cnt_reg) + DIM_W'(1);
    assign row_sum  = DIM_W'(row_cnt_reg) + DIM_W'(1);
    // Four bytes per pixel truncates to zero here, so no pad in that mode.
    assign pad_prod = 2'(width_c[1:0] * bpp[1:0]);

    always_comb begin
        if (cfg.rows_reversed && (DIM_W'(row_cnt_reg) < height_c)) begin
            row_dest = height_c - DIM_W'(1) - DIM_W'(row_cnt_reg);
        end else if (cfg.rows_reversed) begin
            row_dest = '0;
        end else begin
            row_dest = DIM_W'(row_cnt_reg);
        end
    end

    assign col_wide = 32'(col_cnt_reg);
    assign row_wide = 32'(row_dest);

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    always_comb begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        pad_next     = pad_reg;
        q_push       = 1'b0;
        q_entry      = '0;
        if (accept) begin
            priority if (s_data.cmd == bmpck_pkg::CMD_PAL_WRITE) begin
                q_push        = 1'b1;
                q_entry.kind  = bmpck_pkg::KIND_PAL_WR;
                q_entry.index = s_data.palette_index;
                q_entry.red   = s_data.palette_red;
                q_entry.green = s_data.palette_green;
                q_entry.blue  = s_data.palette_blue;
            end else if (pad_reg != 2'd0) begin
                pad_next = pad_reg - 2'd1;
            end else if (({1'b0, phase_reg} + 3'd1) < bpp) begin
                unique case (phase_reg)
                    2'd0:    held_next[7:0]   = s_data.data_byte;
                    2'd1:    held_next[15:8]  = s_data.data_byte;
                    default: held_next[23:16] = s_data.data_byte;
                endcase
                phase_next = phase_reg + 2'd1;
            end else begin
                q_push         = 1'b1;
                q_entry.column = col_wide[11:0];
                q_entry.row    = row_wide[11:0];
                q_entry.index  = s_data.data_byte;
                if (bpp == 3'd1) begin
                    q_entry.kind = bmpck_pkg::KIND_LOOKUP;
                end else if (bpp == 3'd3) begin
                    q_entry.kind  = bmpck_pkg::KIND_DIRECT;
                    q_entry.red   = s_data.data_byte;
                    q_entry.green = held_reg[15:8];
                    q_entry.blue  = held_reg[7:0];
                    q_entry.alpha = bmpck_pkg::ALPHA_OPAQUE;
                end else begin
                    q_entry.kind  = bmpck_pkg::KIND_DIRECT;
                    q_entry.red   = held_reg[23:16];
                    q_entry.green = held_reg[15:8];
                    q_entry.blue  = held_reg[7:0];
                    q_entry.alpha = s_data.data_byte;
                end
                phase_next = 2'd0;
                held_next  = '0;
                if (col_sum >= width_c) begin
                    col_cnt_next = '0;
                    pad_next     = 2'(2'd0 - pad_prod);
                    if (row_sum >= height_c) begin
                        row_cnt_next       = '0;
                        q_entry.last_pixel = 1'b1;
                    end else begin
                        row_cnt_next = CNT_W'(row_sum);
                    end
                end else begin
                    col_cnt_next = CNT_W'(col_sum);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart) begin
            phase_reg   <= '0;
            held_reg    <= '0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pad_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            pad_reg     <= pad_next;
        end
    end

endmodule

/* rtl/core/bmpck_queue.sv */
module bmpck_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bmpck_pkg::entry_t   push_entry,
    output logic                in_ready,
    input  logic                pop,
    output logic                out_valid,
    output bmpck_pkg::entry_t   out_entry
);

    bmpck_pkg::entry_t                entries_reg [bmpck_pkg::QUEUE_DEPTH];
    logic [bmpck_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bmpck_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bmpck_pkg::QCNT_W-1:0]     count_reg,  count_next;

    assign in_ready  = count_reg != bmpck_pkg::QCNT_W'(bmpck_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + bmpck_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + bmpck_pkg::QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + bmpck_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - bmpck_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/bmpck_back.sv */
`include "assert_macros.svh"

module bmpck_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          key_green,
    input  logic                q_valid,
    input  bmpck_pkg::entry_t   q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bmpck_pkg::out_t     m_data
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    logic [23:0]        pal_mem [PALETTE_DEPTH];
    logic [23:0]        rd_data_reg;
    logic               b1_valid_reg, b1_valid_next;
    bmpck_pkg::entry_t  b1_entry_reg;
    logic               b1_in_range_reg;
    logic               m_valid_reg, m_valid_next;
    bmpck_pkg::out_t    m_data_reg;
    bmpck_pkg::out_t    pix;

    logic               b1_adv;
    logic               in_range;
    logic [PAL_AW-1:0]  pal_addr;
    logic               is_pal_wr;

    assign in_range  = 32'(q_entry.index) < PALETTE_DEPTH;
    assign pal_addr  = q_entry.index[PAL_AW-1:0];
    assign is_pal_wr = q_entry.kind == bmpck_pkg::KIND_PAL_WR;

    // Move the held pixel on when the output register is free or draining.
    assign b1_adv = b1_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop  = q_valid && (!b1_valid_reg || b1_adv);

    always_comb begin
        if (q_pop) begin
            b1_valid_next = !is_pal_wr;
        end else if (b1_adv) begin
            b1_valid_next = 1'b0;
        end else begin
            b1_valid_next = b1_valid_reg;
        end
        if (b1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Palette port: one write or one registered read per popped beat.
    always_ff @(posedge aclk) begin
        if (q_pop && is_pal_wr && in_range) begin
            pal_mem[pal_addr] <= {q_entry.red, q_entry.green, q_entry.blue};
        end
        if (q_pop && (q_entry.kind == bmpck_pkg::KIND_LOOKUP)) begin
            rd_data_reg <= pal_mem[pal_addr];
        end
    end

    always_comb begin
        pix.column     = b1_entry_reg.column;
        pix.row        = b1_entry_reg.row;
        pix.last_pixel = b1_entry_reg.last_pixel;
        unique case (b1_entry_reg.kind)
            bmpck_pkg::KIND_LOOKUP: begin
                {pix.red, pix.green, pix.blue} = b1_in_range_reg ? rd_data_reg : 24'd0;
                pix.alpha = bmpck_pkg::ALPHA_OPAQUE;
            end
            default: begin
                pix.red   = b1_entry_reg.red;
                pix.green = b1_entry_reg.green;
                pix.blue  = b1_entry_reg.blue;
                pix.alpha = b1_entry_reg.alpha;
            end
        endcase
        if ((pix.red == 8'd0) && (pix.blue == 8'd0) && (pix.green == key_green)) begin
            pix.alpha = bmpck_pkg::ALPHA_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !is_pal_wr) begin
            b1_entry_reg    <= q_entry;
            b1_in_range_reg <= in_range;
        end
        if (b1_adv) begin
            m_data_reg <= pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            b1_valid_reg <= b1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_NEXT(a_pal_wr_no_pixel, aclk, aresetn, q_pop && is_pal_wr, !b1_valid_reg)
    `ASSERT_NEXT(a_pixel_pop_loads, aclk, aresetn, q_pop && !is_pal_wr, b1_valid_reg)
    `ASSERT_NEXT(a_stall_keeps_b1, aclk, aresetn, b1_valid_reg && m_valid_reg && !m_ready, b1_valid_reg)

endmodule

/* rtl/core/bmp_pixel_unpack_color_key_unit.sv */
// A pixel's last beat passes the queue, the b1 register and the output register to m_valid.
// Throughput: one input beat per cycle while the queue has room, palette writes and padding
// bytes included; the single palette RAM port serves one write or one lookup per cycle.
// The 4-entry queue between front and back absorbs short output stalls.
// Reset: aresetn is synchronous, active low; it clears stream position, queue and
// output valid, and loads mode 24-bit, 1x1 frame; the palette RAM is not cleared.
module bmp_pixel_unpack_color_key_unit #(
    parameter int MAX_DIM       = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB-style register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpck_pkg::ADDR_W-1:0]  paddr,
    input  logic [bmpck_pkg::DATA_W-1:0]  pwdata,
    output logic [bmpck_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    // byte stream and palette writes in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bmpck_pkg::in_t                s_data,
    // RGBA pixels out
    output logic                          m_valid,
    input  logic                          m_ready,
    output bmpck_pkg::out_t               m_data
);

    bmpck_pkg::cfg_t    cfg_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic               cfg_restart;

    logic               q_push, q_pop, q_ready, q_valid;
    bmpck_pkg::entry_t  q_in_entry, q_out_entry;

    // Register file: word index from the byte address, low bits ignored.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    // Any write to a real register rewinds the stream to column 0, row 0.
    assign cfg_restart = wr_en && (reg_idx <= bmpck_pkg::REG_KEY_GREEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_mode    <= bmpck_pkg::MODE_BGR24;
            cfg_reg.image_width   <= 13'd1;
            cfg_reg.image_height  <= 13'd1;
            cfg_reg.rows_reversed <= 1'b0;
            cfg_reg.key_green     <= 8'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                bmpck_pkg::REG_PIXEL_MODE:    cfg_reg.pixel_mode    <= pwdata[1:0];
                bmpck_pkg::REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[12:0];
                bmpck_pkg::REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[12:0];
                bmpck_pkg::REG_ROWS_REVERSED: cfg_reg.rows_reversed <= pwdata[0];
                bmpck_pkg::REG_KEY_GREEN:     cfg_reg.key_green     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bmpck_pkg::REG_PIXEL_MODE:    prdata = 32'(cfg_reg.pixel_mode);
            bmpck_pkg::REG_IMAGE_WIDTH:   prdata = 32'(cfg_reg.image_width);
            bmpck_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(cfg_reg.image_height);
            bmpck_pkg::REG_ROWS_REVERSED: prdata = 32'(cfg_reg.rows_reversed);
            bmpck_pkg::REG_KEY_GREEN:     prdata = 32'(cfg_reg.key_green);
            default:                      prdata = '0;
        endcase
    end

    // Front: track padding, byte phase and position; push palette writes and
    // finished pixels as queue beats.
    bmpck_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cfg_restart (cfg_restart),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_entry     (q_in_entry)
    );

    // Queue: keeps palette writes and lookups in stream order.
    bmpck_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in_entry),
        .in_ready   (q_ready),
        .pop        (q_pop),
        .out_valid  (q_valid),
        .out_entry  (q_out_entry)
    );

    // Back: palette RAM, color key and output register.
    bmpck_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_green (cfg_reg.key_green),
        .q_valid   (q_valid),
        .q_entry   (q_out_entry),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* bench/bmp_pixel_unpack_color_key_unit_tb.sv */
`timescale 1ns / 100ps

module bmp_pixel_unpack_color_key_unit_tb;

    localparam int          CLK_HALF     = 2;
    localparam int          RESET_CYCLES = 4;
    localparam int          MAX_DIM      = 4096;
    localparam int          RANDOM_BEATS = 750;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          SETTLE       = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    // Mode three is decoded like 32-bit BGRA.
    localparam logic [1:0]  MODE_BGRA_ALIAS = 2'd3;

    typedef enum {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        bmpck_pkg::in_t    beat;
        bit                typed;
        bmpck_pkg::out_t   want;
        logic [2:0]        reg_idx;
        logic [31:0]       reg_val;
    } step_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bmpck_pkg::ADDR_W-1:0]    paddr;
    logic [bmpck_pkg::DATA_W-1:0]    pwdata;
    logic [bmpck_pkg::DATA_W-1:0]    prdata;
    logic                            pready;
    logic                            s_valid;
    logic                            s_ready;
    bmpck_pkg::in_t                  s_data;
    logic                            m_valid;
    logic                            m_ready;
    bmpck_pkg::out_t                 m_data;

    // Shadow of the unpacker: palette, register copies and stream position.
    logic [23:0]         pal_mem [256];
    bit                  pal_known [256];
    logic [7:0]          known_idx [$];
    logic [1:0]          cfg_mode;
    logic [12:0]         cfg_w;
    logic [12:0]         cfg_h;
    logic                cfg_rev;
    logic [7:0]          cfg_key;
    int unsigned         byte_idx;
    logic [23:0]         held_bytes;
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    int unsigned         pad_left;

    bmpck_pkg::out_t     pending_pixels [$];
    int unsigned         mismatches;
    int unsigned         beats_sent;
    int unsigned         cycle_cnt;
    bit                  calm;
    bit                  hold_req;
    bit                  hold_done;
    step_row_t           script [];

    bmp_pixel_unpack_color_key_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // Zero reads as one, anything past the largest frame reads as the largest.
    function automatic int unsigned dim_of(logic [12:0] v);
        if (v == 13'd0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return 32'(v);
    endfunction

    // Rewind to column 0, row 0 with no partial pixel and no padding due.
    function automatic void restart_stream();
        byte_idx   = 0;
        held_bytes = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        pad_left   = 0;
    endfunction

    // Advance the shadow by one accepted beat; return 1 when it completes a pixel.
    function automatic bit unpack_byte(input bmpck_pkg::in_t b, output bmpck_pkg::out_t px);
        int unsigned w;
        int unsigned h;
        int unsigned bpp;
        int unsigned dst_row;
        logic [23:0] e;
        px = '0;
        w  = dim_of(cfg_w);
        h  = dim_of(cfg_h);
        case (cfg_mode)
            bmpck_pkg::MODE_PAL8:  bpp = 1;
            bmpck_pkg::MODE_BGR24: bpp = 3;
            default:               bpp = 4;
        endcase

        // Palette writes leave the stream position alone.
        if (b.cmd == bmpck_pkg::CMD_PAL_WRITE) begin
            pal_mem[b.palette_index] = {b.palette_red, b.palette_green, b.palette_blue};
            if (!pal_known[b.palette_index]) begin
                pal_known[b.palette_index] = 1'b1;
                known_idx.push_back(b.palette_index);
            end
            return 1'b0;
        end

        // Drop row padding.
        if (pad_left != 0) begin
            pad_left--;
            return 1'b0;
        end

        // Hold the leading bytes of a multi-byte pixel.
        if (byte_idx + 1 < bpp) begin
            held_bytes[8*byte_idx +: 8] = b.data_byte;
            byte_idx++;
            return 1'b0;
        end

        case (bpp)
            1: begin
                e         = pal_mem[b.data_byte];
                px.red    = e[23:16];
                px.green  = e[15:8];
                px.blue   = e[7:0];
                px.alpha  = bmpck_pkg::ALPHA_OPAQUE;
            end
            3: begin
                px.blue   = held_bytes[7:0];
                px.green  = held_bytes[15:8];
                px.red    = b.data_byte;
                px.alpha  = bmpck_pkg::ALPHA_OPAQUE;
            end
            default: begin
                px.blue   = held_bytes[7:0];
                px.green  = held_bytes[15:8];
                px.red    = held_bytes[23:16];
                px.alpha  = b.data_byte;
            end
        endcase
        if (px.red == 8'd0 && px.blue == 8'd0 && px.green == cfg_key)
            px.alpha = bmpck_pkg::ALPHA_CLEAR;

        byte_idx   = 0;
        held_bytes = '0;

        px.column = col_cnt[11:0];
        if (cfg_rev)
            dst_row = (row_cnt < h) ? (h - 1 - row_cnt) : 0;
        else
            dst_row = row_cnt;
        px.row = dst_row[11:0];

        if (col_cnt + 1 >= w) begin
            col_cnt  = 0;
            pad_left = (4 - ((w * bpp) & 3)) & 3;
            if (row_cnt + 1 >= h) begin
                row_cnt       = 0;
                px.last_pixel = 1'b1;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bmpck_pkg::out_t rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic [7:0] a, logic [11:0] col,
                                             logic [11:0] row, logic last);
        bmpck_pkg::out_t px;
        px.red        = r;
        px.green      = g;
        px.blue       = b;
        px.alpha      = a;
        px.column     = col;
        px.row        = row;
        px.last_pixel = last;
        return px;
    endfunction

    function automatic step_row_t pix_row(logic [7:0] d);
        step_row_t s;
        s.kind           = ROW_BEAT;
        s.beat           = '0;
        s.beat.cmd       = bmpck_pkg::CMD_PIXEL;
        s.beat.data_byte = d;
        s.typed          = 1'b0;
        s.want           = '0;
        s.reg_idx        = '0;
        s.reg_val        = '0;
        return s;
    endfunction

    function automatic step_row_t pix_exp_row(logic [7:0] d, bmpck_pkg::out_t px);
        step_row_t s;
        s       = pix_row(d);
        s.typed = 1'b1;
        s.want  = px;
        return s;
    endfunction

    function automatic step_row_t pal_row(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b);
        step_row_t s;
        s                    = pix_row(8'h00);
        s.beat.cmd           = bmpck_pkg::CMD_PAL_WRITE;
        s.beat.palette_index = idx;
        s.beat.palette_red   = r;
        s.beat.palette_green = g;
        s.beat.palette_blue  = b;
        return s;
    endfunction

    function automatic step_row_t reg_row(logic [2:0] idx, logic [31:0] val);
        step_row_t s;
        s         = pix_row(8'h00);
        s.kind    = ROW_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    // Random beat with content steered toward the key color, black and white.
    // In palette mode a lookup only ever hits an entry that has been written.
    function automatic bmpck_pkg::in_t random_beat(input bit pal_wr);
        bmpck_pkg::in_t b;
        int unsigned    pick;
        b.cmd           = bmpck_pkg::CMD_PIXEL;
        b.data_byte     = 8'($urandom_range(255));
        b.palette_index = 8'($urandom_range(255));
        b.palette_red   = 8'($urandom_range(255));
        b.palette_green = 8'($urandom_range(255));
        b.palette_blue  = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pal_wr || pick < 8) begin
            b.cmd = bmpck_pkg::CMD_PAL_WRITE;
            if ($urandom_range(99) < 30) begin
                b.palette_red   = 8'h00;
                b.palette_green = cfg_key;
                b.palette_blue  = 8'h00;
            end
        end else if (cfg_mode == bmpck_pkg::MODE_PAL8 && pad_left == 0) begin
            b.data_byte = known_idx[$urandom_range(known_idx.size() - 1)];
        end else begin
            pick = $urandom_range(99);
            if (pick < 25)
                b.data_byte = 8'h00;
            else if (pick < 40)
                b.data_byte = cfg_key;
            else if (pick < 50)
                b.data_byte = 8'hFF;
        end
        return b;
    endfunction

    // Offer one beat and hold it until accepted. Enter and leave on a falling edge;
    // valid stays high between back-to-back beats.
    task automatic push_beat(input bmpck_pkg::in_t b, input bit typed,
                             input bmpck_pkg::out_t want);
        bmpck_pkg::out_t px;
        if (!calm) begin
            while ($urandom_range(99) < 11) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        beats_sent++;
        if (unpack_byte(b, px))
            pending_pixels.push_back(typed ? want : px);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every predicted pixel, then let the pipeline drain
    // any trailing padding or palette beats.
    task automatic drain_stream();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // APB write: setup, access, then back to idle with psel low.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            bmpck_pkg::REG_PIXEL_MODE:    cfg_mode = val[1:0];
            bmpck_pkg::REG_IMAGE_WIDTH:   cfg_w    = val[12:0];
            bmpck_pkg::REG_IMAGE_HEIGHT:  cfg_h    = val[12:0];
            bmpck_pkg::REG_ROWS_REVERSED: cfg_rev  = val[0];
            bmpck_pkg::REG_KEY_GREEN:     cfg_key  = val[7:0];
            default: ;
        endcase
        restart_stream();
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted pixel beat with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pixel_check
        bmpck_pkg::out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with nothing predicted: %h", m_data);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("red",        12'(want.red),        12'(m_data.red));
                check_field("green",      12'(want.green),      12'(m_data.green));
                check_field("blue",       12'(want.blue),       12'(m_data.blue));
                check_field("alpha",      12'(want.alpha),      12'(m_data.alpha));
                check_field("column",     want.column,          m_data.column);
                check_field("row",        want.row,             m_data.row);
                check_field("last_pixel", 12'(want.last_pixel), 12'(m_data.last_pixel));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, none while calm, and one long hold-off on request
    // so the internal queue fills and s_ready drops.
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase_no;
        int unsigned plen;
        int unsigned pick;
        logic [1:0]  mode;
        logic [12:0] w;
        logic [12:0] h;
        logic        rev;
        logic [7:0]  key;

        // Drive every input to a known value and hold reset.
        aresetn <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_data  <= '0;
        mismatches = 0;
        beats_sent = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        cfg_mode   = bmpck_pkg::MODE_BGR24;
        cfg_w      = 13'd1;
        cfg_h      = 13'd1;
        cfg_rev    = 1'b0;
        cfg_key    = 8'h00;
        restart_stream();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Reset leaves 24-bit BGR, 1x1, key green 0, rows in order.
        script = '{
            // all-black pixel matches the reset key: alpha cleared, last of a 1x1 image
            pix_row(8'h00), pix_row(8'h00),
            pix_exp_row(8'h00, rgba(8'h00, 8'h00, 8'h00, bmpck_pkg::ALPHA_CLEAR,
                                    12'd0, 12'd0, 1'b1)),
            pix_row(8'hAA),                              // one pad byte per 3-byte row
            // palette write in the middle of a pixel does not move the stream
            pix_row(8'hFF), pal_row(8'h00, 8'h00, 8'h00, 8'h00), pix_row(8'hFF),
            pix_exp_row(8'hFF, rgba(8'hFF, 8'hFF, 8'hFF, bmpck_pkg::ALPHA_OPAQUE,
                                    12'd0, 12'd0, 1'b1)),
            pix_row(8'h55),
            pal_row(8'hFF, 8'hFF, 8'hFF, 8'hFF),
            pal_row(8'h80, 8'h00, 8'h7E, 8'h00),
            // palette mode, 2 wide: two pad bytes per row
            reg_row(bmpck_pkg::REG_PIXEL_MODE, 32'(bmpck_pkg::MODE_PAL8)),
            reg_row(bmpck_pkg::REG_KEY_GREEN, 32'h7E),
            reg_row(bmpck_pkg::REG_IMAGE_WIDTH, 32'd2),
            reg_row(bmpck_pkg::REG_IMAGE_HEIGHT, 32'd1),
            reg_row(bmpck_pkg::REG_ROWS_REVERSED, 32'd0),
            pix_exp_row(8'h80, rgba(8'h00, 8'h7E, 8'h00, bmpck_pkg::ALPHA_CLEAR,
                                    12'd0, 12'd0, 1'b0)),
            pix_exp_row(8'hFF, rgba(8'hFF, 8'hFF, 8'hFF, bmpck_pkg::ALPHA_OPAQUE,
                                    12'd1, 12'd0, 1'b1)),
            pix_row(8'h00), pix_row(8'h00),
            pix_exp_row(8'h00, rgba(8'h00, 8'h00, 8'h00, bmpck_pkg::ALPHA_OPAQUE,
                                    12'd0, 12'd0, 1'b0)),
            // mode three as BGRA, 1x2 mirrored, key green FF
            reg_row(bmpck_pkg::REG_PIXEL_MODE, 32'(MODE_BGRA_ALIAS)),
            reg_row(bmpck_pkg::REG_IMAGE_WIDTH, 32'd1),
            reg_row(bmpck_pkg::REG_IMAGE_HEIGHT, 32'd2),
            reg_row(bmpck_pkg::REG_ROWS_REVERSED, 32'd1),
            reg_row(bmpck_pkg::REG_KEY_GREEN, 32'hFF),
            pix_row(8'h00), pix_row(8'hFF), pix_row(8'h00),
            pix_exp_row(8'h5A, rgba(8'h00, 8'hFF, 8'h00, bmpck_pkg::ALPHA_CLEAR,
                                    12'd0, 12'd1, 1'b0)),
            pix_row(8'h01), pix_row(8'h02), pix_row(8'h03),
            pix_exp_row(8'hC3, rgba(8'h03, 8'h02, 8'h01, 8'hC3, 12'd0, 12'd0, 1'b1)),
            // zero width reads as 1, oversize height as the largest: mirrored row 4095
            reg_row(bmpck_pkg::REG_PIXEL_MODE, 32'(bmpck_pkg::MODE_BGR24)),
            reg_row(bmpck_pkg::REG_IMAGE_WIDTH, 32'd0),
            reg_row(bmpck_pkg::REG_IMAGE_HEIGHT, 32'h1FFF),
            reg_row(bmpck_pkg::REG_KEY_GREEN, 32'h00),
            pix_row(8'h10), pix_row(8'h20),
            pix_exp_row(8'h30, rgba(8'h30, 8'h20, 8'h10, bmpck_pkg::ALPHA_OPAQUE,
                                    12'd0, 12'hFFF, 1'b0)),
            pix_row(8'h00)
        };
        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                drain_stream();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                push_beat(script[i].beat, script[i].typed, script[i].want);
            end
        end

        // Random part: phases of one register setting each, mostly small frames.
        beats_sent = 0;
        phase_no   = 0;
        while (beats_sent < RANDOM_BEATS) begin
            mode = 2'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 75)      w = 13'($urandom_range(9, 1));
            else if (pick < 85) w = 13'($urandom_range(40, 10));
            else if (pick < 90) w = 13'd0;
            else if (pick < 95) w = 13'(MAX_DIM);
            else                w = 13'h1FFF;
            pick = $urandom_range(99);
            if (pick < 80)      h = 13'($urandom_range(4, 1));
            else if (pick < 88) h = 13'($urandom_range(20, 5));
            else if (pick < 93) h = 13'd0;
            else                h = ($urandom_range(1) == 0) ? 13'(MAX_DIM) : 13'h1FFF;
            rev  = 1'($urandom_range(1));
            key  = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
            plen = $urandom_range(90, 30);

            // Widest row in palette mode, cut short long before it ends.
            if (phase_no == 1) begin
                mode = bmpck_pkg::MODE_PAL8;
                w    = 13'(MAX_DIM);
                h    = 13'(MAX_DIM);
                rev  = 1'b1;
                plen = 90;
            end

            drain_stream();
            calm = 1'b0;
            write_reg(bmpck_pkg::REG_PIXEL_MODE, 32'(mode));
            write_reg(bmpck_pkg::REG_IMAGE_WIDTH, 32'(w));
            write_reg(bmpck_pkg::REG_IMAGE_HEIGHT, 32'(h));
            write_reg(bmpck_pkg::REG_ROWS_REVERSED, 32'(rev));
            write_reg(bmpck_pkg::REG_KEY_GREEN, 32'(key));

            // Stall the receiver for a long stretch while beats keep coming.
            if (phase_no == 2) begin
                hold_req = 1'b1;
                plen     = 120;
            end
            // No idling on either side for a whole phase.
            if (phase_no == 4) begin
                calm = 1'b1;
                plen = 150;
            end

            // Refresh a few palette entries, then stream.
            for (int k = 0; k < 4; k++)
                push_beat(random_beat(1'b1), 1'b0, '0);
            for (int k = 0; k < plen; k++)
                push_beat(random_beat(1'b0), 1'b0, '0);
            phase_no++;
        end

        drain_stream();
        calm = 1'b0;
        repeat (2 * SETTLE) @(posedge aclk);

        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
